@@ rtl/core/scored_class_queue_dispatcher_macros.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef SCORED_CLASS_QUEUE_DISPATCHER_MACROS_SVH
`define SCORED_CLASS_QUEUE_DISPATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCQD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/scqd_pkg.sv @@
// Types, codes and reset constants of the scored class queue dispatcher.
`default_nettype none
package scqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int NUM_CLASSES     = 3;
    localparam int SCORE_W         = 10;
    localparam int PROX_W          = 4;
    localparam int ENTRY_W         = SCORE_W + PROX_W;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] CLS_FIRE    = 2'd0;
    localparam logic [1:0] CLS_MEDICAL = 2'd1;
    localparam logic [1:0] CLS_POLICE  = 2'd2;

    localparam logic [2:0] REG_FIRE_WEIGHT    = 3'd0;
    localparam logic [2:0] REG_MEDICAL_WEIGHT = 3'd1;
    localparam logic [2:0] REG_POLICE_WEIGHT  = 3'd2;
    localparam logic [2:0] REG_PROX_REF       = 3'd3;
    localparam logic [2:0] REG_WEATHER_BONUS  = 3'd4;
    localparam logic [2:0] REG_NIGHT_BONUS    = 3'd5;
    localparam logic [2:0] REG_NIGHT_START    = 3'd6;
    localparam logic [2:0] REG_NIGHT_END      = 3'd7;

    localparam logic [6:0] RST_FIRE_WEIGHT    = 7'd30;
    localparam logic [6:0] RST_MEDICAL_WEIGHT = 7'd40;
    localparam logic [6:0] RST_POLICE_WEIGHT  = 7'd25;
    localparam logic [3:0] RST_PROX_REF       = 4'd10;
    localparam logic [4:0] RST_WEATHER_BONUS  = 5'd5;
    localparam logic [4:0] RST_NIGHT_BONUS    = 5'd5;
    localparam logic [4:0] RST_NIGHT_START    = 5'd22;
    localparam logic [4:0] RST_NIGHT_END      = 5'd6;

    localparam logic [2:0] WEATHER_BONUS_CODE = 3'd1;

    typedef struct packed {
        logic [6:0] fire_weight;
        logic [6:0] medical_weight;
        logic [6:0] police_weight;
        logic [3:0] proximity_reference;
        logic [4:0] weather_bonus;
        logic [4:0] night_bonus;
        logic [4:0] night_start_hour;
        logic [4:0] night_end_hour;
    } t_cfg;

    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic nonempty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

@@ rtl/core/scqd_config.sv @@
// APB-style register file holding the scoring weights and bonuses, the proximity reference and the night hours.
`default_nettype none
module scqd_config (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [scqd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [scqd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [scqd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output scqd_pkg::t_cfg                           o_cfg
);

    scqd_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fire_weight         <= scqd_pkg::RST_FIRE_WEIGHT;
            r_cfg.medical_weight      <= scqd_pkg::RST_MEDICAL_WEIGHT;
            r_cfg.police_weight       <= scqd_pkg::RST_POLICE_WEIGHT;
            r_cfg.proximity_reference <= scqd_pkg::RST_PROX_REF;
            r_cfg.weather_bonus       <= scqd_pkg::RST_WEATHER_BONUS;
            r_cfg.night_bonus         <= scqd_pkg::RST_NIGHT_BONUS;
            r_cfg.night_start_hour    <= scqd_pkg::RST_NIGHT_START;
            r_cfg.night_end_hour      <= scqd_pkg::RST_NIGHT_END;
        end else if (wr_en) begin
            case (reg_idx)
                scqd_pkg::REG_FIRE_WEIGHT:    r_cfg.fire_weight         <= pwdata[6:0];
                scqd_pkg::REG_MEDICAL_WEIGHT: r_cfg.medical_weight      <= pwdata[6:0];
                scqd_pkg::REG_POLICE_WEIGHT:  r_cfg.police_weight       <= pwdata[6:0];
                scqd_pkg::REG_PROX_REF:       r_cfg.proximity_reference <= pwdata[3:0];
                scqd_pkg::REG_WEATHER_BONUS:  r_cfg.weather_bonus       <= pwdata[4:0];
                scqd_pkg::REG_NIGHT_BONUS:    r_cfg.night_bonus         <= pwdata[4:0];
                scqd_pkg::REG_NIGHT_START:    r_cfg.night_start_hour    <= pwdata[4:0];
                scqd_pkg::REG_NIGHT_END:      r_cfg.night_end_hour      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            scqd_pkg::REG_FIRE_WEIGHT:    prdata = {25'd0, r_cfg.fire_weight};
            scqd_pkg::REG_MEDICAL_WEIGHT: prdata = {25'd0, r_cfg.medical_weight};
            scqd_pkg::REG_POLICE_WEIGHT:  prdata = {25'd0, r_cfg.police_weight};
            scqd_pkg::REG_PROX_REF:       prdata = {28'd0, r_cfg.proximity_reference};
            scqd_pkg::REG_WEATHER_BONUS:  prdata = {27'd0, r_cfg.weather_bonus};
            scqd_pkg::REG_NIGHT_BONUS:    prdata = {27'd0, r_cfg.night_bonus};
            scqd_pkg::REG_NIGHT_START:    prdata = {27'd0, r_cfg.night_start_hour};
            scqd_pkg::REG_NIGHT_END:      prdata = {27'd0, r_cfg.night_end_hour};
            default:                      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/scqd_queue.sv @@
// One class queue: a ring in a synchronous memory with its pointers and fill count.
`default_nettype none
module scqd_queue #(
    parameter int DEPTH = scqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire scqd_pkg::t_q_ctrl                 i_ctrl,
    input  wire logic [scqd_pkg::ENTRY_W-1:0]      i_wdata,
    output logic      [scqd_pkg::ENTRY_W-1:0]      o_head,
    output scqd_pkg::t_q_status                    o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [scqd_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [scqd_pkg::ENTRY_W-1:0] r_head;
    logic [PTR_W-1:0]             r_rd_ptr;
    logic [PTR_W-1:0]             r_wr_ptr;
    logic [CNT_W-1:0]             r_count;
    logic [PTR_W-1:0]             n_rd_ptr;
    logic [PTR_W-1:0]             n_wr_ptr;
    logic [CNT_W-1:0]             n_count;

    assign o_head          = r_head;
    assign o_status.full     = (r_count == CNT_W'(DEPTH));
    assign o_status.nonempty = (r_count != '0);

    // The memory holds payload only; occupancy tells which entries are live.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
        if (i_ctrl.rd) begin
            r_head <= r_mem[r_rd_ptr];
        end
    end

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_ctrl.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/scored_class_queue_dispatcher.sv @@
// Top level of the scored class queue dispatcher.
//
// Every transaction runs as follows: start is taken when busy is low, busy
// is then high for one cycle while the queue memories are read or written,
// and the single result is shown with o_valid for one cycle after that, in
// the cycle where the next transaction may already be started. The queue
// memories are read synchronously: their heads are read at the start edge
// and compared in the busy cycle. Results cannot be held off, so a result
// must be taken in the cycle o_valid is high. The queues need no clearing
// after reset; their fill counts mark live entries.
`default_nettype none
module scored_class_queue_dispatcher #(
    parameter int QUEUE_DEPTH = scqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_opcode,
    input  wire logic [1:0]                        i_event_class,
    input  wire logic [3:0]                        i_proximity,
    input  wire logic [3:0]                        i_urgency,
    input  wire logic [4:0]                        i_hour_of_day,
    input  wire logic [2:0]                        i_weather_code,
    output logic                                   o_valid,
    output logic                                   o_add_accepted,
    output logic                                   o_dispatched,
    output logic      [1:0]                        o_dispatch_class,
    output logic signed [9:0]                      o_priority_score,
    output logic      [3:0]                        o_dispatch_proximity,
    output logic      [31:0]                       o_tick_time,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scqd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [scqd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [scqd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    `include "scored_class_queue_dispatcher_macros.svh"

    scqd_pkg::t_cfg      cfg;
    scqd_pkg::t_q_ctrl   q_ctrl   [scqd_pkg::NUM_CLASSES];
    scqd_pkg::t_q_status q_status [scqd_pkg::NUM_CLASSES];
    logic [scqd_pkg::ENTRY_W-1:0] q_head  [scqd_pkg::NUM_CLASSES];
    logic signed [9:0]            q_score [scqd_pkg::NUM_CLASSES];
    logic [scqd_pkg::NUM_CLASSES-1:0] q_elig;

    logic        accept;
    logic [9:0]  add_score;
    logic [9:0]  class_weight;
    logic        night;

    logic        r_busy;
    logic        r_op;
    logic [1:0]  r_cls;
    logic [3:0]  r_prox;
    logic [9:0]  r_score;
    logic [31:0] r_tick_cnt;

    logic        r_valid;
    logic        r_add_accepted;
    logic        r_dispatched;
    logic [1:0]  r_dispatch_class;
    logic [9:0]  r_priority_score;
    logic [3:0]  r_dispatch_proximity;
    logic [31:0] r_tick_time;

    logic        n_add_accepted;
    logic        n_dispatched;
    logic [1:0]  n_dispatch_class;
    logic [9:0]  n_priority_score;
    logic [3:0]  n_dispatch_proximity;
    logic [31:0] n_tick_time;

    logic              pick_valid;
    logic [1:0]        pick;
    logic signed [9:0] best;
    logic              push_ok;

    scqd_config u_config (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Score in ten-bit two's complement; all terms wrap together modulo 1024.
    always_comb begin
        case (i_event_class)
            scqd_pkg::CLS_FIRE:    class_weight = {3'd0, cfg.fire_weight};
            scqd_pkg::CLS_MEDICAL: class_weight = {3'd0, cfg.medical_weight};
            scqd_pkg::CLS_POLICE:  class_weight = {3'd0, cfg.police_weight};
            default:               class_weight = '0;
        endcase
        night = (i_hour_of_day >= cfg.night_start_hour) ||
                (i_hour_of_day <= cfg.night_end_hour);
        add_score = class_weight
                  + {5'd0, cfg.proximity_reference, 1'b0}
                  - {5'd0, i_proximity, 1'b0}
                  + {6'd0, i_urgency}
                  + {5'd0, i_urgency, 1'b0}
                  + ((i_weather_code == scqd_pkg::WEATHER_BONUS_CODE)
                        ? {5'd0, cfg.weather_bonus} : 10'd0)
                  + (night ? {5'd0, cfg.night_bonus} : 10'd0);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_cls   <= i_event_class;
            r_prox  <= i_proximity;
            r_score <= add_score;
        end
    end

    genvar g;
    generate
        for (g = 0; g < scqd_pkg::NUM_CLASSES; g++) begin : g_queue
            assign q_ctrl[g].rd   = accept && (i_opcode == scqd_pkg::OP_TICK);
            assign q_ctrl[g].push = r_busy && (r_op == scqd_pkg::OP_ADD)
                                  && (r_cls == 2'(g)) && !q_status[g].full;
            assign q_ctrl[g].pop  = r_busy && (r_op == scqd_pkg::OP_TICK)
                                  && pick_valid && (pick == 2'(g));
            assign q_score[g]     = $signed(q_head[g][scqd_pkg::ENTRY_W-1:scqd_pkg::PROX_W]);
            assign q_elig[g]      = q_status[g].nonempty && !q_score[g][9];

            scqd_queue #(
                .DEPTH (QUEUE_DEPTH)
            ) u_queue (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (q_ctrl[g]),
                .i_wdata  ({r_score, r_prox}),
                .o_head   (q_head[g]),
                .o_status (q_status[g])
            );
        end
    endgenerate

    // Strictly greater wins, so an earlier class keeps a tie.
    always_comb begin
        pick_valid = 1'b0;
        pick       = scqd_pkg::CLS_FIRE;
        best       = '0;
        if (q_elig[0]) begin
            pick_valid = 1'b1;
            pick       = scqd_pkg::CLS_FIRE;
            best       = q_score[0];
        end
        if (q_elig[1] && (!pick_valid || (q_score[1] > best))) begin
            pick_valid = 1'b1;
            pick       = scqd_pkg::CLS_MEDICAL;
            best       = q_score[1];
        end
        if (q_elig[2] && (!pick_valid || (q_score[2] > best))) begin
            pick_valid = 1'b1;
            pick       = scqd_pkg::CLS_POLICE;
            best       = q_score[2];
        end
    end

    assign push_ok = (r_cls == scqd_pkg::CLS_FIRE    && !q_status[0].full) ||
                     (r_cls == scqd_pkg::CLS_MEDICAL && !q_status[1].full) ||
                     (r_cls == scqd_pkg::CLS_POLICE  && !q_status[2].full);

    always_comb begin
        n_add_accepted       = 1'b0;
        n_dispatched         = 1'b0;
        n_dispatch_class     = '0;
        n_priority_score     = '0;
        n_dispatch_proximity = '0;
        n_tick_time          = '0;
        if (r_op == scqd_pkg::OP_ADD) begin
            n_add_accepted   = push_ok;
            n_priority_score = r_score;
        end else begin
            n_tick_time = r_tick_cnt;
            if (pick_valid) begin
                n_dispatched         = 1'b1;
                n_dispatch_class     = pick;
                n_priority_score     = best;
                n_dispatch_proximity = q_head[pick][scqd_pkg::PROX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_valid    <= 1'b0;
            r_tick_cnt <= '0;
        end else begin
            r_busy  <= accept;
            r_valid <= r_busy;
            if (r_busy && (r_op == scqd_pkg::OP_TICK)) begin
                r_tick_cnt <= r_tick_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_add_accepted       <= n_add_accepted;
            r_dispatched         <= n_dispatched;
            r_dispatch_class     <= n_dispatch_class;
            r_priority_score     <= n_priority_score;
            r_dispatch_proximity <= n_dispatch_proximity;
            r_tick_time          <= n_tick_time;
        end
    end

    assign o_valid              = r_valid;
    assign o_add_accepted       = r_add_accepted;
    assign o_dispatched         = r_dispatched;
    assign o_dispatch_class     = r_dispatch_class;
    assign o_priority_score     = $signed(r_priority_score);
    assign o_dispatch_proximity = r_dispatch_proximity;
    assign o_tick_time          = r_tick_time;

    `SCQD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid, "accepted transaction did not enter the busy cycle")
    `SCQD_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_valid && !busy, "busy cycle not followed by exactly one result")
    `SCQD_ASSERT_NOW(a_result_kind, i_clk, i_rst_n, o_valid, !(o_add_accepted && o_dispatched), "result reports both an add and a dispatch")

endmodule
`default_nettype wire
